FILE: design/prte_pkg.sv
package prte_pkg;

    localparam int ID_DIGITS    = 4;
    localparam int RADIX        = 4;
    localparam int CONTACT_BITS = 48;

    localparam int ID_W     = 8;
    localparam int DIG_W    = $clog2(RADIX);
    localparam int TSIZE    = ID_DIGITS * RADIX;
    localparam int IDX_W    = $clog2(TSIZE);
    localparam int PLEN_W   = $clog2(ID_DIGITS + 1);
    localparam int DPOS_W   = $clog2(ID_DIGITS);
    localparam int DEC_W    = 4 * ID_DIGITS;
    localparam int PLEN_OUT = 3;
    localparam int COL_OUT  = 2;

    localparam logic [1:0] OP_JOIN  = 2'd0;
    localparam logic [1:0] OP_ROUTE = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_LEAF  = 2'd3;

    localparam logic [1:0] CFG_OWN_ID      = 2'd0;
    localparam logic [1:0] CFG_OWN_CONTACT = 2'd1;

    localparam int SLOT_L2 = 0;
    localparam int SLOT_L1 = 1;
    localparam int SLOT_U1 = 2;
    localparam int SLOT_U2 = 3;

    localparam logic [2:0] NEAR_LAST = 3'd4;

    typedef logic [ID_W-1:0]         t_id;
    typedef logic [CONTACT_BITS-1:0] t_contact;
    typedef logic [DIG_W-1:0]        t_digit;
    typedef t_digit [ID_DIGITS-1:0]  t_digits;
    typedef t_id [3:0]               t_leaf_ids;

    typedef struct packed {
        logic              wr;
        logic              full;
        logic [IDX_W-1:0]  idx;
        logic [PLEN_W-1:0] plen;
        t_digit            cand_dig;
        t_digit            own_dig;
    } t_offer;

    typedef struct packed {
        logic                found;
        t_id                 id;
        t_contact            contact;
        logic [PLEN_OUT-1:0] plen;
        logic [COL_OUT-1:0]  col;
        logic                last;
    } t_res;

    // digit i is the i-th most significant; bits beyond the space drop out
    function automatic t_digits id_digits(input t_id id);
        t_digits d;
        int      v;
        v = int'(id);
        for (int i = ID_DIGITS - 1; i >= 0; i--) begin
            d[i] = DIG_W'(v % RADIX);
            v    = v / RADIX;
        end
        return d;
    endfunction

    function automatic t_id norm_id(input t_id id);
        t_digits d;
        int      r;
        d = id_digits(id);
        r = 0;
        for (int i = 0; i < ID_DIGITS; i++) r = r * RADIX + int'(d[i]);
        return ID_W'(r);
    endfunction

    function automatic logic [PLEN_W-1:0] shared_prefix(input t_id a, input t_id b);
        t_digits da;
        t_digits db;
        logic    run;
        int      p;
        da  = id_digits(a);
        db  = id_digits(b);
        run = 1'b1;
        p   = 0;
        for (int i = 0; i < ID_DIGITS; i++) begin
            if (run && da[i] == db[i]) p = p + 1;
            else run = 1'b0;
        end
        return PLEN_W'(p);
    endfunction

    function automatic logic [DEC_W-1:0] decimal_reading(input t_id id);
        t_digits           d;
        logic [DEC_W-1:0]  r;
        d = id_digits(id);
        r = '0;
        for (int i = 0; i < ID_DIGITS; i++) r = DEC_W'(r * 10) + DEC_W'(d[i]);
        return r;
    endfunction

endpackage

FILE: design/prte_offer.sv
module prte_offer import prte_pkg::*; (
    input  t_id              i_cand,
    input  t_id              i_own,
    input  logic [3:0]       i_leaf_vld,
    input  t_leaf_ids        i_leaf_id,
    input  logic [TSIZE-1:0] i_tab_vld,
    output t_offer           o_offer
);

    t_digits           cand_d;
    t_digits           own_d;
    logic [PLEN_W-1:0] p;
    logic              full;
    logic [IDX_W-1:0]  idx;
    logic              in_range;

    always_comb begin
        cand_d = id_digits(i_cand);
        own_d  = id_digits(i_own);
        p      = shared_prefix(i_own, i_cand);
        full   = (int'(p) >= ID_DIGITS);
        idx    = full ? '0
                      : IDX_W'(int'(p) * RADIX + int'(cand_d[p[DPOS_W-1:0]]));

        if (i_cand > i_own) begin
            in_range = !i_leaf_vld[SLOT_U1] || !i_leaf_vld[SLOT_U2]
                       || (i_leaf_id[SLOT_U2] > i_cand);
        end else if (i_cand < i_own) begin
            in_range = !i_leaf_vld[SLOT_L1] || !i_leaf_vld[SLOT_L2]
                       || (i_leaf_id[SLOT_L2] < i_cand);
        end else begin
            in_range = 1'b0;
        end

        o_offer.wr       = !full && (!i_tab_vld[idx] || !in_range);
        o_offer.full     = full;
        o_offer.idx      = idx;
        o_offer.plen     = p;
        o_offer.cand_dig = full ? '0 : cand_d[p[DPOS_W-1:0]];
        o_offer.own_dig  = full ? '0 : own_d[p[DPOS_W-1:0]];
    end

endmodule

FILE: design/prte_nearest.sv
module prte_nearest import prte_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_id        i_key,
    input  logic       i_cand_vld,
    input  t_id        i_cand_id,
    output logic [2:0] o_sel,
    output logic       o_done,
    output logic       o_have,
    output logic [2:0] o_best
);

    logic             r_busy;
    logic [2:0]       r_i;
    logic             r_have;
    logic [DEC_W-1:0] r_best_d;
    logic [2:0]       r_best;
    logic             r_done;

    logic [DEC_W-1:0] kd;
    logic [DEC_W-1:0] cd;
    logic [DEC_W-1:0] diff;
    logic             take;

    // one candidate per cycle through the shared subtractor
    always_comb begin
        kd   = decimal_reading(i_key);
        cd   = decimal_reading(i_cand_id);
        diff = (cd > kd) ? cd - kd : kd - cd;
        take = r_busy && i_cand_vld && (!r_have || diff < r_best_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_have <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_have <= 1'b0;
            end else if (r_busy) begin
                if (take) r_have <= 1'b1;
                if (r_i == NEAR_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_d <= diff;
            r_best   <= r_i;
        end
    end

    assign o_sel  = r_i;
    assign o_done = r_done;
    assign o_have = r_have;
    assign o_best = r_best;

endmodule

FILE: design/prefix_route_table_engine_core.sv
// Join: leaf update and table offer, then one row entry per cycle while the
// output is not stalled; four results, or one if the node ID is the own ID.
// Route: five candidates through one distance unit when the key falls in the
// leaf range. Table write: no result. One request at a time, set by the
// sequencer. Reset (synchronous, active low) clears all valid bits, the own
// ID and contact and the sequencer; the block is ready once reset is released.
module prefix_route_table_engine_core import prte_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  t_contact            i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  t_id                 i_node_id,
    input  t_contact            i_contact,
    input  logic [1:0]          i_row,
    input  logic [1:0]          i_column,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output t_id                 o_entry_id,
    output t_contact            o_entry_contact,
    output logic [PLEN_OUT-1:0] o_prefix_len,
    output logic [COL_OUT-1:0]  o_entry_column,
    output logic                o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEAF  = 3'd1;
    localparam logic [2:0] S_OFFER = 3'd2;
    localparam logic [2:0] S_ROUTE = 3'd3;
    localparam logic [2:0] S_NEAR  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]        r_state;
    t_id               r_own_id;
    t_contact          r_own_ct;
    logic [TSIZE-1:0]  r_tab_vld;
    t_id               r_tab_id [TSIZE];
    t_contact          r_tab_ct [TSIZE];
    logic [3:0]        r_leaf_vld;
    t_leaf_ids         r_leaf_id;
    t_contact          r_leaf_ct [4];

    logic [1:0]        r_op;
    t_id               r_x;
    t_contact          r_c;
    logic              r_acc;
    logic [PLEN_W-1:0] r_plen;
    t_digit            r_dx;
    t_digit            r_dn;
    logic [DIG_W-1:0]  r_k;
    t_res              r_res;
    t_res              r_out;
    logic              r_ov;

    t_id               own;
    logic              accept;
    logic              out_free;

    logic [3:0]        n_leaf_vld;
    t_leaf_ids         n_leaf_id;
    t_contact          n_leaf_ct [4];
    logic              leaf_acc;
    logic              leaf_disp;
    logic [1:0]        nr;
    logic [1:0]        fr;
    logic              up;

    t_id               cand;
    t_contact          cand_ct;
    t_offer            offer;
    logic              tab_we;

    logic              near_start;
    logic [2:0]        near_sel;
    logic              near_done;
    logic              near_have;
    logic [2:0]        near_best;
    logic              near_vld;
    t_id               near_id;
    t_id               best_id;
    t_contact          best_ct;
    t_id               hi;
    t_id               lo;

    logic [IDX_W-1:0]  emit_idx;
    t_res              emit_res;
    t_res              route_res;

    assign own      = norm_id(r_own_id);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ov || !i_out_stall;

    // leaf set decision for the held node
    function automatic logic better(input logic upper, input t_id a, input t_id x);
        return upper ? (a > x) : (a < x);
    endfunction

    always_comb begin
        n_leaf_vld = r_leaf_vld;
        n_leaf_id  = r_leaf_id;
        for (int s = 0; s < 4; s++) n_leaf_ct[s] = r_leaf_ct[s];
        leaf_acc  = 1'b1;
        leaf_disp = 1'b0;
        up        = (r_x > own);
        nr        = up ? 2'(SLOT_U1) : 2'(SLOT_L1);
        fr        = up ? 2'(SLOT_U2) : 2'(SLOT_L2);
        if (r_x != own) begin
            if (!r_leaf_vld[nr]) begin
                n_leaf_vld[nr] = 1'b1;
                n_leaf_id[nr]  = r_x;
                n_leaf_ct[nr]  = r_c;
            end else if (!r_leaf_vld[fr] || better(up, r_leaf_id[nr], r_x)) begin
                leaf_disp = r_leaf_vld[fr];
                n_leaf_vld[fr] = 1'b1;
                if (better(up, r_leaf_id[nr], r_x)) begin
                    n_leaf_id[fr] = r_leaf_id[nr];
                    n_leaf_ct[fr] = r_leaf_ct[nr];
                    n_leaf_id[nr] = r_x;
                    n_leaf_ct[nr] = r_c;
                end else begin
                    n_leaf_id[fr] = r_x;
                    n_leaf_ct[fr] = r_c;
                end
            end else if (better(up, r_leaf_id[fr], r_x)) begin
                leaf_disp     = 1'b1;
                n_leaf_id[fr] = r_x;
                n_leaf_ct[fr] = r_c;
            end else begin
                leaf_acc = 1'b0;
            end
        end
    end

    // the displaced far neighbour is offered first, the node itself after
    always_comb begin
        if (r_state == S_LEAF) begin
            cand    = r_leaf_id[fr];
            cand_ct = r_leaf_ct[fr];
        end else begin
            cand    = r_x;
            cand_ct = r_c;
        end
    end

    prte_offer u_offer (
        .i_cand     (cand),
        .i_own      (own),
        .i_leaf_vld (r_leaf_vld),
        .i_leaf_id  (r_leaf_id),
        .i_tab_vld  (r_tab_vld),
        .o_offer    (offer)
    );

    always_comb begin
        priority case (r_state)
            S_LEAF:  tab_we = leaf_disp && offer.wr;
            S_OFFER: tab_we = offer.wr && (r_op == OP_JOIN || r_acc);
            default: tab_we = 1'b0;
        endcase
    end

    // route bounds and candidate order: far lower, near lower, own, near upper, far upper
    always_comb begin
        hi = r_leaf_vld[SLOT_U2] ? r_leaf_id[SLOT_U2]
           : (r_leaf_vld[SLOT_U1] ? r_leaf_id[SLOT_U1] : own);
        lo = r_leaf_vld[SLOT_L2] ? r_leaf_id[SLOT_L2]
           : (r_leaf_vld[SLOT_L1] ? r_leaf_id[SLOT_L1] : own);
        unique case (near_sel)
            3'd0:    begin near_vld = r_leaf_vld[SLOT_L2]; near_id = r_leaf_id[SLOT_L2]; end
            3'd1:    begin near_vld = r_leaf_vld[SLOT_L1]; near_id = r_leaf_id[SLOT_L1]; end
            3'd2:    begin near_vld = 1'b1;                near_id = own;                end
            3'd3:    begin near_vld = r_leaf_vld[SLOT_U1]; near_id = r_leaf_id[SLOT_U1]; end
            default: begin near_vld = r_leaf_vld[SLOT_U2]; near_id = r_leaf_id[SLOT_U2]; end
        endcase
        unique case (near_best)
            3'd0:    begin best_id = r_leaf_id[SLOT_L2]; best_ct = r_leaf_ct[SLOT_L2]; end
            3'd1:    begin best_id = r_leaf_id[SLOT_L1]; best_ct = r_leaf_ct[SLOT_L1]; end
            3'd2:    begin best_id = own;                best_ct = r_own_ct;           end
            3'd3:    begin best_id = r_leaf_id[SLOT_U1]; best_ct = r_leaf_ct[SLOT_U1]; end
            default: begin best_id = r_leaf_id[SLOT_U2]; best_ct = r_leaf_ct[SLOT_U2]; end
        endcase
    end

    assign near_start = (r_state == S_ROUTE) && (r_x != own) && (r_x < hi) && (r_x > lo);

    prte_nearest u_near (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (near_start),
        .i_key      (r_x),
        .i_cand_vld (near_vld),
        .i_cand_id  (near_id),
        .o_sel      (near_sel),
        .o_done     (near_done),
        .o_have     (near_have),
        .o_best     (near_best)
    );

    always_comb begin
        emit_idx = IDX_W'(int'(r_plen) * RADIX + int'(r_k));
        emit_res.plen = PLEN_OUT'(r_plen);
        emit_res.col  = COL_OUT'(r_k);
        emit_res.last = (int'(r_k) == RADIX - 1);
        if (r_k == r_dx) begin
            emit_res.found   = 1'b0;
            emit_res.id      = '0;
            emit_res.contact = '0;
        end else if (r_k == r_dn) begin
            emit_res.found   = 1'b1;
            emit_res.id      = own;
            emit_res.contact = r_own_ct;
        end else begin
            emit_res.found   = r_tab_vld[emit_idx];
            emit_res.id      = r_tab_vld[emit_idx] ? r_tab_id[emit_idx] : '0;
            emit_res.contact = r_tab_vld[emit_idx] ? r_tab_ct[emit_idx] : '0;
        end

        route_res.plen    = '0;
        route_res.col     = '0;
        route_res.last    = 1'b1;
        route_res.found   = (r_x != own) && !offer.full && r_tab_vld[offer.idx];
        route_res.id      = route_res.found ? r_tab_id[offer.idx] : '0;
        route_res.contact = route_res.found ? r_tab_ct[offer.idx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_own_id   <= '0;
            r_own_ct   <= '0;
            r_tab_vld  <= '0;
            r_leaf_vld <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OWN_ID:      r_own_id <= i_cfg_data[ID_W-1:0];
                    CFG_OWN_CONTACT: r_own_ct <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_PUT || r_state == S_EMIT) && out_free) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
            if (tab_we) r_tab_vld[offer.idx] <= 1'b1;
            if (accept && i_op == OP_WRITE && int'(i_row) < ID_DIGITS
                && int'(i_column) < RADIX) begin
                r_tab_vld[IDX_W'(int'(i_row) * RADIX + int'(i_column))] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        priority case (i_op)
                            OP_ROUTE: r_state <= S_ROUTE;
                            OP_WRITE: r_state <= S_IDLE;
                            default:  r_state <= S_LEAF;
                        endcase
                    end
                end
                S_LEAF: begin
                    r_leaf_vld <= n_leaf_vld;
                    r_state    <= S_OFFER;
                end
                S_OFFER: begin
                    r_state <= (r_op == OP_JOIN && !offer.full) ? S_EMIT : S_PUT;
                end
                S_ROUTE: r_state <= near_start ? S_NEAR : S_PUT;
                S_NEAR:  if (near_done) r_state <= S_PUT;
                S_PUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (out_free && emit_res.last) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload: request, leaf contents, table contents, results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
            r_x  <= norm_id(i_node_id);
            r_c  <= i_contact;
            r_k  <= '0;
            if (i_op == OP_WRITE && int'(i_row) < ID_DIGITS && int'(i_column) < RADIX) begin
                r_tab_id[IDX_W'(int'(i_row) * RADIX + int'(i_column))] <= norm_id(i_node_id);
                r_tab_ct[IDX_W'(int'(i_row) * RADIX + int'(i_column))] <= i_contact;
            end
        end
        if (tab_we) begin
            r_tab_id[offer.idx] <= cand;
            r_tab_ct[offer.idx] <= cand_ct;
        end
        if (r_state == S_LEAF) begin
            r_leaf_id <= n_leaf_id;
            for (int s = 0; s < 4; s++) r_leaf_ct[s] <= n_leaf_ct[s];
            r_acc <= leaf_acc;
        end
        if (r_state == S_OFFER) begin
            r_plen <= offer.plen;
            r_dx   <= offer.cand_dig;
            r_dn   <= offer.own_dig;
            r_res.found   <= (r_op == OP_LEAF) && r_acc;
            r_res.id      <= '0;
            r_res.contact <= '0;
            r_res.plen    <= (r_op == OP_JOIN) ? PLEN_OUT'(offer.plen) : '0;
            r_res.col     <= '0;
            r_res.last    <= 1'b1;
        end
        if (r_state == S_ROUTE) r_res <= route_res;
        if (r_state == S_NEAR && near_done) begin
            r_res.found   <= near_have && (best_id != own);
            r_res.id      <= (near_have && best_id != own) ? best_id : '0;
            r_res.contact <= (near_have && best_id != own) ? best_ct : '0;
            r_res.plen    <= '0;
            r_res.col     <= '0;
            r_res.last    <= 1'b1;
        end
        if (r_state == S_PUT && out_free) r_out <= r_res;
        if (r_state == S_EMIT && out_free) begin
            r_out <= emit_res;
            r_k   <= r_k + DIG_W'(1);
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_found         = r_out.found;
    assign o_entry_id      = r_out.id;
    assign o_entry_contact = r_out.contact;
    assign o_prefix_len    = r_out.plen;
    assign o_entry_column  = r_out.col;
    assign o_last          = r_out.last;

`ifndef SYNTH
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_entry_id == '0 && o_entry_contact == '0)
        else $error("empty result carries an entry");

    a_near_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        near_done |-> r_state == S_NEAR)
        else $error("distance search finished outside route");

    a_emit_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> int'(r_plen) < ID_DIGITS && r_op == OP_JOIN)
        else $error("row report without a table row");

    a_leaf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LEAF |=> r_state == S_OFFER)
        else $error("leaf update not followed by table offer");
`endif

endmodule
